FILE: design/dpt_pkg.sv
`timescale 1ns / 1ps
package dpt_pkg;

  typedef enum logic [1:0] {
    KIND_WRITE_ATTR = 2'd0,
    KIND_ADD_EDGE   = 2'd1,
    KIND_SET_ORDER  = 2'd2,
    KIND_PICK       = 2'd3
  } kind_t;

  localparam int unsigned CFG_TASKS_IN_USE = 0;
  localparam int unsigned CFG_ATTRS_IN_USE = 1;
  localparam int unsigned CFG_INIT_ORDER   = 2;
  localparam int unsigned KEY_SLOTS        = 5;

  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  task_req;
    logic [2:0]  attribute;
    logic [15:0] value;
    logic [5:0]  successor;
    logic [14:0] key_order;
  } in_item_t;

  typedef struct packed {
    logic [5:0] picked_task;
    logic       none_ready;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_ADD,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_EDGE_RD,
    ST_EDGE_UPD,
    ST_EDGE_WR,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic load_item;
    logic exec;
    logic edge_add;
    logic scan_start;
    logic scan_rd;
    logic scan_cmp;
    logic edge_start;
    logic edge_rd;
    logic edge_upd;
    logic edge_wr;
    logic emit;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic is_pick;
    logic is_edge;
    logic scan_last;
    logic cmp_last;
    logic found;
    logic edge_last;
    logic edges_none;
  } stat_t;

endpackage

FILE: design/dpt_ram.sv
`timescale 1ns / 1ps
module dpt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: design/dpt_ctrl.sv
`timescale 1ns / 1ps
module dpt_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  dpt_pkg::stat_t stat,
  output dpt_pkg::ctrl_t ctrl
);
  import dpt_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:    if (stat.clear_last) state_next = ST_IDLE;
      ST_IDLE:     if (in_valid) state_next = ST_EXEC;
      ST_EXEC: begin
        if (stat.is_pick) state_next = ST_SCAN_RD;
        else if (stat.is_edge) state_next = ST_ADD;
        else state_next = ST_IDLE;
      end
      ST_ADD:      state_next = ST_IDLE;
      ST_SCAN_RD:  state_next = ST_SCAN_CMP;
      ST_SCAN_CMP: begin
        // every key slot and every task gets its own pass through ST_SCAN_RD
        if (!stat.cmp_last || !stat.scan_last) state_next = ST_SCAN_RD;
        else if (stat.found && !stat.edges_none) state_next = ST_EDGE_RD;
        else state_next = ST_DONE;
      end
      ST_EDGE_RD:  state_next = ST_EDGE_UPD;
      ST_EDGE_UPD: state_next = ST_EDGE_WR;
      ST_EDGE_WR:  state_next = stat.edge_last ? ST_DONE : ST_EDGE_RD;
      ST_DONE:     if (!out_stall) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl      = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    case (state)
      ST_CLEAR:    ctrl.clear = 1'b1;
      ST_IDLE: begin
        in_stall       = 1'b0;
        ctrl.load_item = in_valid;
      end
      ST_EXEC: begin
        ctrl.exec       = 1'b1;
        ctrl.scan_start = stat.is_pick;
      end
      ST_ADD:      ctrl.edge_add = 1'b1;
      ST_SCAN_RD:  ctrl.scan_rd = 1'b1;
      ST_SCAN_CMP: begin
        ctrl.scan_cmp   = 1'b1;
        ctrl.edge_start = stat.cmp_last && stat.scan_last;
      end
      ST_EDGE_RD:  ctrl.edge_rd = 1'b1;
      ST_EDGE_UPD: ctrl.edge_upd = 1'b1;
      ST_EDGE_WR:  ctrl.edge_wr = 1'b1;
      ST_DONE: begin
        out_valid = 1'b1;
        ctrl.emit = !out_stall;
      end
      default: ;
    endcase
  end
endmodule

FILE: design/dpt_datapath.sv
`timescale 1ns / 1ps
module dpt_datapath #(
  parameter int MAX_TASKS = 64,
  parameter int MAX_ATTRS = 5,
  parameter int MAX_EDGES = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  dpt_pkg::in_item_t in_item,
  input  dpt_pkg::ctrl_t    ctrl,
  output dpt_pkg::stat_t    stat,
  output dpt_pkg::out_item_t out_item,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [14:0]       cfg_data
);
  import dpt_pkg::*;

  localparam int TW = $clog2(MAX_TASKS);
  localparam int AW = (MAX_ATTRS > 1) ? $clog2(MAX_ATTRS) : 1;
  localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ADW = $clog2(MAX_TASKS * MAX_ATTRS);
  localparam int CW = $clog2(MAX_EDGES + 1);
  localparam int PW = CW;
  localparam int KW = $clog2(KEY_SLOTS);

  // configuration
  logic [6:0]  tasks_in_use;
  logic [2:0]  attrs_in_use;
  logic [14:0] key_order;

  in_item_t item;

  logic [CW-1:0] edge_count;
  logic [TW-1:0] clr_i;

  // scan registers
  logic [TW:0]   scan_t;
  logic [TW-1:0] cur_t;
  logic [KW-1:0] slot;
  logic          found;
  logic [TW-1:0] best;
  logic          cand_ok;
  logic          cand_wins;
  logic          decided;
  logic          beats;
  logic [EW:0]   edge_i;

  // limits
  logic [TW:0] n_tasks;
  logic [2:0]  m_attrs;
  logic [2:0]  slots;
  always_comb begin
    n_tasks = (32'(tasks_in_use) > MAX_TASKS) ? (TW+1)'(MAX_TASKS) : (TW+1)'(tasks_in_use);
    m_attrs = (32'(attrs_in_use) > MAX_ATTRS) ? 3'(MAX_ATTRS) : attrs_in_use;
    slots   = (m_attrs > 3'(KEY_SLOTS)) ? 3'(KEY_SLOTS) : m_attrs;
  end

  logic [2:0] key_idx;
  assign key_idx = key_order[3*slot +: 3];

  // attribute memory, two ports: candidate and best, each its own instance
  logic          a_we;
  logic [ADW-1:0] a_waddr, a_raddr_c, a_raddr_b;
  logic [15:0]   a_cand, a_best;
  logic          item_addr_ok;

  assign item_addr_ok = (32'(item.task_req) < MAX_TASKS) && (32'(item.attribute) < MAX_ATTRS);
  assign a_we    = ctrl.exec && (item.kind == KIND_WRITE_ATTR) && item_addr_ok;
  assign a_waddr = ADW'(32'(item.task_req) * MAX_ATTRS + 32'(item.attribute));
  assign a_raddr_c = ADW'(32'(cur_t) * MAX_ATTRS + 32'(key_idx[AW-1:0]));
  assign a_raddr_b = ADW'(32'(best) * MAX_ATTRS + 32'(key_idx[AW-1:0]));

  dpt_ram #(.WIDTH(16), .DEPTH(MAX_TASKS * MAX_ATTRS)) u_attr_c (
    .clk, .we(a_we), .waddr(a_waddr), .wdata(item.value), .raddr(a_raddr_c), .rdata(a_cand)
  );
  dpt_ram #(.WIDTH(16), .DEPTH(MAX_TASKS * MAX_ATTRS)) u_attr_b (
    .clk, .we(a_we), .waddr(a_waddr), .wdata(item.value), .raddr(a_raddr_b), .rdata(a_best)
  );

  // edge memory holds predecessor and successor
  logic          e_we;
  logic [2*TW-1:0] e_rdata;
  logic          edge_ok;
  assign edge_ok = (32'(item.task_req) < MAX_TASKS) && (32'(item.successor) < MAX_TASKS)
                   && (32'(edge_count) < MAX_EDGES);
  assign e_we = ctrl.edge_add && (item.kind == KIND_ADD_EDGE) && edge_ok;

  dpt_ram #(.WIDTH(2*TW), .DEPTH(MAX_EDGES)) u_edge (
    .clk, .we(e_we), .waddr(edge_count[EW-1:0]),
    .wdata({TW'(item.task_req), TW'(item.successor)}),
    .raddr(edge_i[EW-1:0]), .rdata(e_rdata)
  );

  // task state memory, one entry per task: issued flag over pending count
  logic          s_we;
  logic [TW-1:0] s_waddr, s_raddr;
  logic [PW:0]   s_wdata, s_rdata;
  logic          s_issued;
  logic [PW-1:0] s_pend;
  logic          edge_hit;

  assign s_issued = s_rdata[PW];
  assign s_pend   = s_rdata[PW-1:0];
  assign edge_hit = (e_rdata[2*TW-1:TW] == best) && (s_pend != '0);

  always_comb begin
    if (ctrl.edge_upd) s_raddr = e_rdata[TW-1:0];
    else if (ctrl.scan_rd) s_raddr = cur_t;
    else s_raddr = TW'(item.successor);
  end

  always_comb begin
    s_we    = 1'b0;
    s_waddr = TW'(item.successor);
    s_wdata = {s_issued, s_pend + 1'b1};
    if (ctrl.clear) begin
      s_we    = 1'b1;
      s_waddr = clr_i;
      s_wdata = '0;
    end else if (ctrl.edge_start) begin
      // the winner is ready, so its count is zero
      s_we    = stat.found;
      s_waddr = cand_wins ? cur_t : best;
      s_wdata = {1'b1, {PW{1'b0}}};
    end else if (ctrl.edge_wr) begin
      s_we    = edge_hit;
      s_waddr = e_rdata[TW-1:0];
      s_wdata = {s_issued, s_pend - 1'b1};
    end else if (ctrl.edge_add) begin
      s_we    = e_we;
    end
  end

  dpt_ram #(.WIDTH(PW + 1), .DEPTH(MAX_TASKS)) u_task (
    .clk, .we(s_we), .waddr(s_waddr), .wdata(s_wdata), .raddr(s_raddr), .rdata(s_rdata)
  );

  logic slot_used;
  assign slot_used = key_idx < m_attrs;

  // task state read in scan_rd is on hand during scan_cmp
  assign cand_ok   = (scan_t < n_tasks) && !s_issued && (s_pend == '0);
  assign cand_wins = cand_ok && (!found || !beats);

  assign stat.clear_last = (32'(clr_i) == MAX_TASKS - 1);
  assign stat.is_pick    = (item.kind == KIND_PICK);
  assign stat.is_edge    = (item.kind == KIND_ADD_EDGE);
  assign stat.scan_last  = (scan_t + 1'b1) >= n_tasks;
  assign stat.cmp_last   = !cand_ok || !found || decided
                           || (32'(slot) + 1 >= 32'(slots)) || (slots == 3'd0)
                           || (slot_used && a_cand != a_best);
  assign stat.found      = found || cand_ok;
  assign stat.edge_last  = (32'(edge_i) + 1 >= 32'(edge_count));
  assign stat.edges_none = (edge_count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      tasks_in_use <= 7'd64;
      attrs_in_use <= 3'd5;
      key_order    <= 15'd18056;
      edge_count   <= '0;
      found        <= 1'b0;
      clr_i        <= '0;
    end else begin
      if (cfg_we) begin
        case (32'(cfg_index))
          CFG_TASKS_IN_USE: tasks_in_use <= cfg_data[6:0];
          CFG_ATTRS_IN_USE: attrs_in_use <= cfg_data[2:0];
          CFG_INIT_ORDER:   key_order    <= cfg_data;
          default: ;
        endcase
      end
      if (ctrl.exec && item.kind == KIND_SET_ORDER) key_order <= item.key_order;
      if (e_we) edge_count <= edge_count + 1'b1;
      if (ctrl.clear) clr_i <= clr_i + 1'b1;
      if (ctrl.scan_start) found <= 1'b0;
      // candidate wins unless best ranks strictly above it
      if (ctrl.scan_cmp && stat.cmp_last && cand_wins) found <= 1'b1;
    end
  end

  // best ranks above candidate when the first differing used slot favors best
  always_comb begin
    beats = 1'b0;
    if (!decided && slot_used && a_cand != a_best && 32'(slot) < 32'(slots)) begin
      beats = a_best > a_cand;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_item) item <= in_item;
    if (ctrl.scan_start) begin
      scan_t <= '0;
      cur_t  <= '0;
      slot   <= '0;
    end
    if (ctrl.scan_rd) decided <= 1'b0;
    if (ctrl.scan_cmp) begin
      if (stat.cmp_last) begin
        if (cand_wins) best <= cur_t;
        scan_t <= scan_t + 1'b1;
        cur_t  <= cur_t + 1'b1;
        slot   <= '0;
      end else begin
        slot <= slot + 1'b1;
      end
    end
    if (ctrl.edge_start) begin
      edge_i <= '0;
      out_item.picked_task <= 6'(stat.found ? (cand_wins ? cur_t : best) : '0);
      out_item.none_ready  <= !stat.found;
    end
    if (ctrl.edge_wr) edge_i <= edge_i + 1'b1;
  end

  // each slot goes back through scan_rd so the rams are read at the new slot
endmodule

FILE: design/dependency_priority_task_picker_top.sv
`timescale 1ns / 1ps
// channel | signals                  | accepted when
// in      | in_valid in_stall in_item | in_valid && !in_stall
// out     | out_valid out_stall out_item | out_valid && !out_stall
// cfg     | cfg_valid cfg_ready cfg_index cfg_data | cfg_valid && cfg_ready
// steps: attribute writes and order changes pass IDLE, EXEC; edges also ADD; a pick runs
//   SCAN_RD, SCAN_CMP per key slot compared for each task (once for one not ready), then
//   EDGE_RD, EDGE_UPD, EDGE_WR per stored edge once one issues, DONE; scan and sweep dominate
// reset: synchronous, registers to defaults and edge count cleared, then ST_CLEAR walks every
//   task entry to clear the pending counts and issued flags
// stalls: input held off while clearing and while an item is in progress; a pick holds out
module dependency_priority_task_picker_top #(
  parameter int MAX_TASKS = 64,
  parameter int MAX_ATTRS = 5,
  parameter int MAX_EDGES = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  dpt_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output dpt_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [14:0]        cfg_data
);
  import dpt_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  // configuration always accepted
  assign cfg_ready = 1'b1;

  dpt_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .stat, .ctrl
  );

  dpt_datapath #(
    .MAX_TASKS(MAX_TASKS), .MAX_ATTRS(MAX_ATTRS), .MAX_EDGES(MAX_EDGES)
  ) u_dp (
    .clk, .rst, .in_item, .ctrl, .stat, .out_item,
    .cfg_we(cfg_valid && cfg_ready), .cfg_index, .cfg_data
  );

`ifndef ASSERT_OFF
  // never accept input while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input taken during output");
  // a stalled result stays valid until it is taken
  a_emit_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");
  // every load is followed by exec
  a_load: assert property (@(posedge clk) disable iff (rst)
    ctrl.load_item |=> ctrl.exec) else $error("load not followed by exec");
`endif
endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import dpt_pkg::*;

  localparam int LIMIT = 5000000;
  localparam int NT = 64;
  localparam int NA = 5;
  localparam int NE = 256;

  // keeps its own copy of the scheduler state and predicts every pick
  class pick_scoreboard;
    bit [15:0] attr_mem [NT][NA];
    int        pend [NT];
    bit        issued [NT];
    bit [5:0]  edge_pred [NE];
    bit [5:0]  edge_succ [NE];
    int        edge_cnt;
    bit [14:0] cur_order;
    int        tasks_cfg;
    int        attrs_cfg;
    out_item_t pick_q [$];
    int        errors;

    function new();
      tasks_cfg = 64;
      attrs_cfg = 5;
      cur_order = 15'd18056;
      edge_cnt  = 0;
      errors    = 0;
      foreach (pend[i]) begin
        pend[i] = 0;
        issued[i] = 0;
      end
    endfunction

    task report(string msg);
      $display("mismatch @%0t: %s", $realtime, msg);
      errors++;
    endtask

    function void note_cfg(int idx, bit [14:0] data);
      if (idx == CFG_TASKS_IN_USE) tasks_cfg = int'(data[6:0]);
      else if (idx == CFG_ATTRS_IN_USE) attrs_cfg = int'(data[2:0]);
      else if (idx == CFG_INIT_ORDER) cur_order = data;
    endfunction

    // a ranks strictly above b, comparing attributes in key order
    function bit outranks(int a, int b);
      int m;
      int idx;
      m = attrs_cfg > NA ? NA : attrs_cfg;
      for (int k = 0; k < m && k < KEY_SLOTS; k++) begin
        idx = int'(cur_order[3*k +: 3]);
        if (idx < m && attr_mem[a][idx] != attr_mem[b][idx])
          return attr_mem[a][idx] > attr_mem[b][idx];
      end
      return 0;
    endfunction

    function void note_item(in_item_t it);
      int n;
      int best;
      bit found;
      out_item_t r;
      case (kind_t'(it.kind))
        KIND_WRITE_ATTR: begin
          if (it.attribute < NA) attr_mem[it.task_req][it.attribute] = it.value;
        end
        KIND_ADD_EDGE: begin
          if (edge_cnt < NE) begin
            edge_pred[edge_cnt] = it.task_req;
            edge_succ[edge_cnt] = it.successor;
            edge_cnt++;
            pend[it.successor]++;
          end
        end
        KIND_SET_ORDER: cur_order = it.key_order;
        default: begin
          n = tasks_cfg > NT ? NT : tasks_cfg;
          found = 0;
          best = 0;
          for (int t = 0; t < n; t++) begin
            if (!issued[t] && pend[t] == 0 && (!found || !outranks(best, t))) begin
              best = t;
              found = 1;
            end
          end
          if (!found) begin
            r.picked_task = 0;
            r.none_ready = 1;
          end else begin
            issued[best] = 1;
            for (int e = 0; e < edge_cnt; e++)
              if (edge_pred[e] == best && pend[edge_succ[e]] != 0) pend[edge_succ[e]]--;
            r.picked_task = 6'(best);
            r.none_ready = 0;
          end
          pick_q.insert(pick_q.size(), r);
        end
      endcase
    endfunction

    task check_pick(out_item_t got);
      out_item_t want;
      if (pick_q.size() == 0) begin
        report($sformatf("unexpected result task=%0d none=%0b", got.picked_task,
                         got.none_ready));
      end else begin
        want = pick_q.pop_front();
        if (got.picked_task !== want.picked_task)
          report($sformatf("picked_task got %0d want %0d", got.picked_task,
                           want.picked_task));
        if (got.none_ready !== want.none_ready)
          report($sformatf("none_ready got %0b want %0b", got.none_ready,
                           want.none_ready));
      end
    endtask
  endclass

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [1:0]  cfg_index;
  logic [14:0] cfg_data;

  pick_scoreboard sb;
  int cycle_cnt;
  int burst_left;
  int stall_mode;
  int stall_left;

  dependency_priority_task_picker_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // 2 ns clock
  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // watchdog on total run length
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver stall pattern: switches mode now and then, mode 0 never stalls
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 200);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: out_stall = 1'b0;
      1: out_stall = 1'($urandom_range(0, 1));
      2: out_stall = (cycle_cnt % 5) < 3;
      default: out_stall = ($urandom_range(0, 15) != 0);
    endcase
  end

  // results are taken at the rising edge where valid meets no stall
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_pick(out_item);
  end

  // one item through the input channel; sender runs in bursts with gaps
  task send_item(in_item_t it);
    @(negedge clk);
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_item = it;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_item(it);
  endtask

  task go_quiet();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // register write, only once the block has drained
  task write_reg(int idx, bit [14:0] data);
    go_quiet();
    while (sb.pick_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = 2'(idx);
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    sb.note_cfg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic in_item_t mk(kind_t k, int t, int a, int v, int s, int o);
    in_item_t it;
    it.kind = k;
    it.task_req = 6'(t);
    it.attribute = 3'(a);
    it.value = 16'(v);
    it.successor = 6'(s);
    it.key_order = 15'(o);
    return it;
  endfunction

  // random item with weighted kinds; edges mostly point forward to stay acyclic
  function automatic in_item_t rand_item(int pick_pct, int edge_pct);
    in_item_t it;
    int r;
    it = mk(KIND_WRITE_ATTR, $urandom, $urandom, $urandom, $urandom, $urandom);
    r = $urandom_range(0, 99);
    if (r < pick_pct) begin
      it.kind = KIND_PICK;
    end else if (r < pick_pct + edge_pct) begin
      it.kind = KIND_ADD_EDGE;
      if ($urandom_range(0, 4) != 0 && it.task_req < 63)
        it.successor = 6'($urandom_range(it.task_req + 1, 63));
    end else if (r < pick_pct + edge_pct + 12) begin
      it.kind = KIND_SET_ORDER;
    end else if ($urandom_range(0, 9) == 0) begin
      it.attribute = 3'($urandom_range(5, 7));  // out of range, dropped
    end else begin
      it.attribute = 3'($urandom_range(0, 4));
    end
    return it;
  endfunction

  initial begin
    sb = new();
    cycle_cnt = 0;
    burst_left = 0;
    stall_mode = 0;
    stall_left = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // fill every attribute first so no pick ever reads an unwritten entry;
    // task 0 all ones, task 63 all zeros, tasks 10 and 11 identical for ties
    for (int t = 0; t < NT; t++)
      for (int a = 0; a < NA; a++)
        send_item(mk(KIND_WRITE_ATTR, t, a,
                     t == 0 ? 16'hffff : t == 63 ? 0 : (t == 10 || t == 11) ? 77 + a
                     : $urandom, $urandom, $urandom));

    // directed: picks at reset order, ignored writes, dependencies, late edge
    send_item(mk(KIND_PICK, 0, 0, 0, 0, 0));                 // task 0 wins outright
    send_item(mk(KIND_WRITE_ATTR, 5, 7, 16'hffff, 0, 0));     // attribute out of range
    send_item(mk(KIND_ADD_EDGE, 0, 0, 0, 12, 0));             // late edge from issued task
    send_item(mk(KIND_ADD_EDGE, 11, 0, 0, 13, 0));
    send_item(mk(KIND_ADD_EDGE, 13, 0, 0, 14, 0));
    send_item(mk(KIND_ADD_EDGE, 13, 0, 0, 14, 0));            // duplicate edge
    send_item(mk(KIND_SET_ORDER, 0, 0, 0, 0, 15'h7fff));      // all slots unused: all tie
    send_item(mk(KIND_PICK, 0, 0, 0, 0, 0));                  // tie goes to highest index
    send_item(mk(KIND_SET_ORDER, 0, 0, 0, 0, 15'o00004));     // repeated slots, attr 4 first
    send_item(mk(KIND_PICK, 0, 0, 0, 0, 0));
    send_item(mk(KIND_PICK, 0, 0, 0, 0, 0));
    send_item(mk(KIND_SET_ORDER, 0, 0, 0, 0, 0));
    send_item(mk(KIND_PICK, 0, 0, 0, 0, 0));
    write_reg(CFG_ATTRS_IN_USE, 15'd1);
    send_item(mk(KIND_PICK, 0, 0, 0, 0, 0));
    write_reg(CFG_TASKS_IN_USE, 15'd0);                       // nothing in use: none ready
    send_item(mk(KIND_PICK, 0, 0, 0, 0, 0));
    write_reg(CFG_TASKS_IN_USE, 15'd1);                       // task 0 already issued
    send_item(mk(KIND_PICK, 0, 0, 0, 0, 0));
    write_reg(CFG_ATTRS_IN_USE, 15'd0);
    write_reg(CFG_TASKS_IN_USE, 15'd12);
    send_item(mk(KIND_PICK, 0, 0, 0, 0, 0));                  // no attributes compared
    write_reg(CFG_INIT_ORDER, 15'o01234);                     // reversed order

    // phase 1: full size, few picks so dependencies pile up
    write_reg(CFG_TASKS_IN_USE, 15'd64);
    write_reg(CFG_ATTRS_IN_USE, 15'd5);
    for (int i = 0; i < 40; i++) send_item(rand_item(10, 50));

    // phase 2: oversize registers, then fill the edge store past its end
    write_reg(CFG_TASKS_IN_USE, 15'd127);
    write_reg(CFG_ATTRS_IN_USE, 15'd7);
    write_reg(CFG_INIT_ORDER, 15'h7fff);
    for (int i = 0; i < 25; i++) send_item(rand_item(12, 50));
    while (sb.edge_cnt < NE) send_item(rand_item(0, 100));
    for (int i = 0; i < 5; i++) send_item(rand_item(0, 100));

    // phase 3: small configurations, pick heavy until tasks run out
    write_reg(CFG_TASKS_IN_USE, 15'($urandom_range(1, 30)));
    write_reg(CFG_ATTRS_IN_USE, 15'($urandom_range(1, 3)));
    write_reg(CFG_INIT_ORDER, 15'($urandom));
    for (int i = 0; i < 20; i++) send_item(rand_item(30, 10));
    write_reg(CFG_TASKS_IN_USE, 15'd64);
    write_reg(CFG_ATTRS_IN_USE, 15'd5);
    write_reg(CFG_INIT_ORDER, 15'd18056);
    for (int i = 0; i < 20; i++) send_item(rand_item(35, 5));
    go_quiet();

    while (sb.pick_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pick_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
